[sv/kcah_pkg.sv]
package kcah_pkg;

  localparam logic [31:0] CrcPoly      = 32'hEDB8_8320;
  localparam logic [7:0]  Separator    = 8'h2E;
  localparam int          KeyWidth     = 16;
  localparam int          SegCount     = 4;
  localparam logic [KeyWidth-1:0] KeyOneReset   = 16'd23857;
  localparam logic [KeyWidth-1:0] KeyTwoReset   = 16'd38447;
  localparam logic [KeyWidth-1:0] KeyThreeReset = 16'd64709;

  typedef enum logic [1:0] {
    CfgKeyOne   = 2'd0,
    CfgKeyTwo   = 2'd1,
    CfgKeyThree = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [KeyWidth-1:0] one;
    logic [KeyWidth-1:0] two;
    logic [KeyWidth-1:0] three;
  } keys_t;

  typedef struct packed {
    logic [SegCount-1:0][31:0] crc;
    logic                      too_few;
  } seg_view_t;

  typedef struct packed {
    logic [29:0] hash_fourth;
    logic [29:0] hash_third;
    logic [30:0] hash_second;
    logic [29:0] hash_first;
    logic        too_few_segments;
  } result_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/kcah_in_if.sv]
interface kcah_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

[sv/kcah_out_if.sv]
interface kcah_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] hash_fourth;
  logic [29:0] hash_third;
  logic [30:0] hash_second;
  logic [29:0] hash_first;
  logic        too_few_segments;

  modport source (output valid, output hash_fourth, output hash_third, output hash_second,
                  output hash_first, output too_few_segments, input ready);
  modport sink (input valid, input hash_fourth, input hash_third, input hash_second,
                input hash_first, input too_few_segments, output ready);
endinterface

[sv/kcah_seg.sv]
module kcah_seg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  last_byte_i,
  output kcah_pkg::seg_view_t   view_o
);
  import kcah_pkg::*;

  logic [31:0]               running_q, running_d;
  logic [SegCount-1:0][31:0] crcs_q, crcs_d;
  logic [2:0]                seen_q, seen_d;
  logic                      inside_q, inside_d;

  logic        is_sep;
  logic        open_seg;
  logic [31:0] cur_crc;
  logic        do_close;
  logic        store;
  logic [2:0]  seen_view;

  always_comb begin
    is_sep   = (text_byte_i == Separator);
    open_seg = is_sep ? inside_q : 1'b1;
    cur_crc  = is_sep ? running_q : crc_byte(inside_q ? running_q : 32'd0, text_byte_i);
    do_close = is_sep || last_byte_i;
    store    = do_close && open_seg && (seen_q < 3'(SegCount));

    view_o.crc = crcs_q;
    seen_view  = seen_q;
    if (store) begin
      view_o.crc[seen_q[1:0]] = cur_crc;
      seen_view = seen_q + 3'd1;
    end
    view_o.too_few = (seen_view < 3'(SegCount));

    running_d = running_q;
    crcs_d    = crcs_q;
    seen_d    = seen_q;
    inside_d  = inside_q;
    if (step_i) begin
      if (last_byte_i) begin
        running_d = '0;
        crcs_d    = '0;
        seen_d    = '0;
        inside_d  = 1'b0;
      end else if (is_sep) begin
        running_d = '0;
        crcs_d    = view_o.crc;
        seen_d    = seen_view;
        inside_d  = 1'b0;
      end else begin
        running_d = cur_crc;
        inside_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      crcs_q    <= '0;
      seen_q    <= '0;
      inside_q  <= 1'b0;
    end else begin
      running_q <= running_d;
      crcs_q    <= crcs_d;
      seen_q    <= seen_d;
      inside_q  <= inside_d;
    end
  end

endmodule

[sv/kcah_mix.sv]
module kcah_mix (
  input  kcah_pkg::seg_view_t view_i,
  input  kcah_pkg::keys_t     keys_i,
  output kcah_pkg::result_t   result_o
);
  import kcah_pkg::*;

  logic [31:0] k1, k2, k3;
  logic [31:0] h4, h3, h2, h1;

  always_comb begin
    k1 = {16'd0, keys_i.one};
    k2 = {16'd0, keys_i.two};
    k3 = {16'd0, keys_i.three};
    h4 = (view_i.crc[3] + k1) ^ k2 ^ k3;
    h3 = ((k2 ^ view_i.crc[2]) + k3) ^ k1;
    h2 = (view_i.crc[1] + k3) ^ k1 ^ k2;
    h1 = ((k3 ^ view_i.crc[0]) + k2) ^ k1;
    result_o.hash_fourth      = h4[29:0];
    result_o.hash_third       = h3[29:0];
    result_o.hash_second      = h2[30:0];
    result_o.hash_first       = h1[29:0];
    result_o.too_few_segments = view_i.too_few;
  end

endmodule

[sv/keyed_crc32_address_cloak_hash.sv]
// Hashes dotted address text, one byte per input word, into four keyed CRC-32
// segment hashes. A word is taken every cycle unless stalled: it is registered at
// the input, and from there the byte-wise CRC update and segment bookkeeping run;
// on the word marked last the keyed mix is computed in that same cycle and lands
// in the output register. The block stalls only when a finished result is still
// waiting at the output. Keys are written through the cfg port (index 0..2); the
// user must write them only while no address is in flight (not enforced here).
module keyed_crc32_address_cloak_hash (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [kcah_pkg::KeyWidth-1:0]   cfg_data_i,
  kcah_in_if.sink                         in_i,
  kcah_out_if.source                      out_o
);
  import kcah_pkg::*;

  keys_t      keys_q;
  logic       vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       out_vld_q;
  result_t    out_q;

  logic       step;
  logic       out_free;
  seg_view_t  view;
  result_t    result;

  assign out_free  = !out_vld_q || out_o.ready;
  assign step      = vld_q && (!last_q || out_free);
  assign in_i.ready = !vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '{one: KeyOneReset, two: KeyTwoReset, three: KeyThreeReset};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeyOne:   keys_q.one   <= cfg_data_i;
        CfgKeyTwo:   keys_q.two   <= cfg_data_i;
        CfgKeyThree: keys_q.three <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.text_byte;
      last_q <= in_i.last_byte;
    end
  end

  kcah_seg u_seg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .text_byte_i (byte_q),
    .last_byte_i (last_q),
    .view_o      (view)
  );

  kcah_mix u_mix (
    .view_i   (view),
    .keys_i   (keys_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      out_q <= result;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.hash_fourth      = out_q.hash_fourth;
  assign out_o.hash_third       = out_q.hash_third;
  assign out_o.hash_second      = out_q.hash_second;
  assign out_o.hash_first       = out_q.hash_first;
  assign out_o.too_few_segments = out_q.too_few_segments;

endmodule
